// File: rtl/dtspv_pkg.sv
// ---------------------------------------------------------------------------
// dtspv_pkg
// Shared types, constants and character helpers for the date/time string
// parser and calendar checker.
// ---------------------------------------------------------------------------
package dtspv_pkg;

  // Character buffer and length counter
  localparam int STORE_DEPTH = 19;
  localparam int COUNT_W     = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd20;

  // Recognized string lengths
  localparam logic [COUNT_W-1:0] LEN_DATE         = 5'd8;
  localparam logic [COUNT_W-1:0] LEN_DATE_SEP     = 5'd10;
  localparam logic [COUNT_W-1:0] LEN_DATETIME     = 5'd14;
  localparam logic [COUNT_W-1:0] LEN_DATETIME_SEP = 5'd19;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // Field and result widths
  localparam int YEAR_W   = 15;  // signed, -999..9999
  localparam int PAIR_W   = 8;   // signed, -9..99
  localparam int YMD_W    = 28;  // signed YYYYMMDD
  localparam int HMS_W    = 21;  // signed HHMMSS
  localparam int PACKED_W = 48;

  localparam logic signed [PACKED_W-1:0] SCALE_DAY = 48'sd1000000;

  // Reciprocal of 100 for year values below 10000
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    FORM_BAD_LEN      = 3'd0,
    FORM_DATE         = 3'd1,
    FORM_DATE_SEP     = 3'd2,
    FORM_DATETIME     = 3'd3,
    FORM_DATETIME_SEP = 3'd4,
    FORM_REJECT       = 3'd5
  } form_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_beat_t;

  typedef struct packed {
    logic signed [PACKED_W-1:0] packed_value;
    form_t                      form_code;
    logic                       is_valid;
  } result_beat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  // Two-character field: digits, or minus then digit; anything else is 0
  function automatic logic signed [PAIR_W-1:0] field2(input logic [7:0] a,
                                                      input logic [7:0] b);
    logic signed [PAIR_W-1:0] val;
    val = '0;
    if (is_digit(a) && is_digit(b)) begin
      val = $signed(8'(a[3:0]) * 8'd10 + 8'(b[3:0]));
    end else if ((a == CHAR_MINUS) && is_digit(b)) begin
      val = -$signed(8'(b[3:0]));
    end
    return val;
  endfunction

  // Four-character field: digits, or minus then three digits
  function automatic logic signed [YEAR_W-1:0] field4(input logic [7:0] a,
                                                      input logic [7:0] b,
                                                      input logic [7:0] c,
                                                      input logic [7:0] d);
    logic [YEAR_W-1:0]        tail;
    logic signed [YEAR_W-1:0] val;
    tail = 15'(b[3:0]) * 15'd100 + 15'(c[3:0]) * 15'd10 + 15'(d[3:0]);
    val  = '0;
    if (is_digit(b) && is_digit(c) && is_digit(d)) begin
      if (is_digit(a)) begin
        val = $signed(15'(a[3:0]) * 15'd1000 + tail);
      end else if (a == CHAR_MINUS) begin
        val = -$signed(tail);
      end
    end
    return val;
  endfunction

endpackage

// File: rtl/date_time_string_parse_validate.sv
// A result beat passes through three registered stages (field decode, calendar
// normalize, packed multiply-add) after its final character is accepted.
// Throughput: one character per cycle, results back to back; the input only
// stalls when all three result stages are full and the output is held off.
// Reset (rst, synchronous) clears the length count and stage valids; the
// character buffer is not reset.
// ---------------------------------------------------------------------------
// date_time_string_parse_validate
// Buffers a date/time string one character per beat and, on the final
// character, emits packed YYYYMMDDHHMMSS, the recognized form and a calendar
// validity flag.
// ---------------------------------------------------------------------------
module date_time_string_parse_validate (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    char_valid,
  output logic                    char_ready,
  input  dtspv_pkg::char_beat_t   char_data,
  output logic                    result_valid,
  input  logic                    result_ready,
  output dtspv_pkg::result_beat_t result_data
);

  localparam int CW = dtspv_pkg::COUNT_W;
  localparam int YW = dtspv_pkg::YEAR_W;
  localparam int PW = dtspv_pkg::PAIR_W;

  // Pipeline control
  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready, s3_ready;
  logic char_acc, final_acc;

  assign s3_ready   = !result_valid || result_ready;
  assign s2_ready   = !s2_valid || s3_ready;
  assign s1_ready   = !s1_valid || s2_ready;
  assign char_ready = s1_ready;
  assign char_acc   = char_valid && char_ready;
  assign final_acc  = char_acc && char_data.last_char;

  // Character buffer and saturating length count
  logic [7:0]    store [dtspv_pkg::STORE_DEPTH];
  logic [CW-1:0] count;
  logic [CW-1:0] len_now;

  assign len_now = (count < dtspv_pkg::COUNT_MAX) ? count + 5'd1 : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (char_acc) begin
      count <= char_data.last_char ? '0 : len_now;
    end
  end

  always_ff @(posedge clk) begin
    if (char_acc && (count < CW'(dtspv_pkg::STORE_DEPTH))) begin
      store[count] <= char_data.char_code;
    end
  end

  // Buffer view with the incoming character merged at its slot
  logic [7:0] ch [dtspv_pkg::STORE_DEPTH];

  always_comb begin
    for (int i = 0; i < dtspv_pkg::STORE_DEPTH; i++) begin
      ch[i] = (count == CW'(i)) ? char_data.char_code : store[i];
    end
  end

  // Stage 1: form detection and field conversion
  logic                   dig8, dig14;
  dtspv_pkg::form_t       form_next;
  logic signed [YW-1:0]   year_next;
  logic signed [PW-1:0]   mon_next, day_next, hour_next, min_next, sec_next;

  always_comb begin
    dig8  = 1'b1;
    dig14 = 1'b1;
    for (int i = 0; i < 8; i++) begin
      dig8 = dig8 & dtspv_pkg::is_digit(ch[i]);
    end
    for (int i = 0; i < 14; i++) begin
      dig14 = dig14 & dtspv_pkg::is_digit(ch[i]);
    end
  end

  always_comb begin
    form_next = dtspv_pkg::FORM_BAD_LEN;
    year_next = '0;
    mon_next  = '0;
    day_next  = '0;
    hour_next = '0;
    min_next  = '0;
    sec_next  = '0;
    case (len_now)
      dtspv_pkg::LEN_DATE: begin
        form_next = dtspv_pkg::FORM_REJECT;
        if (dig8) begin
          form_next = dtspv_pkg::FORM_DATE;
          year_next = dtspv_pkg::field4(ch[0], ch[1], ch[2], ch[3]);
          mon_next  = dtspv_pkg::field2(ch[4], ch[5]);
          day_next  = dtspv_pkg::field2(ch[6], ch[7]);
        end
      end
      dtspv_pkg::LEN_DATE_SEP: begin
        form_next = dtspv_pkg::FORM_REJECT;
        if (ch[4] == ch[7]) begin
          form_next = dtspv_pkg::FORM_DATE_SEP;
          year_next = dtspv_pkg::field4(ch[0], ch[1], ch[2], ch[3]);
          mon_next  = dtspv_pkg::field2(ch[5], ch[6]);
          day_next  = dtspv_pkg::field2(ch[8], ch[9]);
        end
      end
      dtspv_pkg::LEN_DATETIME: begin
        form_next = dtspv_pkg::FORM_REJECT;
        if (dig14) begin
          form_next = dtspv_pkg::FORM_DATETIME;
          year_next = dtspv_pkg::field4(ch[0], ch[1], ch[2], ch[3]);
          mon_next  = dtspv_pkg::field2(ch[4], ch[5]);
          day_next  = dtspv_pkg::field2(ch[6], ch[7]);
          hour_next = dtspv_pkg::field2(ch[8], ch[9]);
          min_next  = dtspv_pkg::field2(ch[10], ch[11]);
          sec_next  = dtspv_pkg::field2(ch[12], ch[13]);
        end
      end
      dtspv_pkg::LEN_DATETIME_SEP: begin
        form_next = dtspv_pkg::FORM_REJECT;
        if ((ch[4] == ch[7]) && (ch[13] == ch[16])) begin
          form_next = dtspv_pkg::FORM_DATETIME_SEP;
          year_next = dtspv_pkg::field4(ch[0], ch[1], ch[2], ch[3]);
          mon_next  = dtspv_pkg::field2(ch[5], ch[6]);
          day_next  = dtspv_pkg::field2(ch[8], ch[9]);
          hour_next = dtspv_pkg::field2(ch[11], ch[12]);
          min_next  = dtspv_pkg::field2(ch[14], ch[15]);
          sec_next  = dtspv_pkg::field2(ch[17], ch[18]);
        end
      end
      default: begin
        form_next = dtspv_pkg::FORM_BAD_LEN;
      end
    endcase
  end

  dtspv_pkg::form_t     s1_form;
  logic signed [YW-1:0] s1_year;
  logic signed [PW-1:0] s1_mon, s1_day, s1_hour, s1_min, s1_sec;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= final_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_form <= form_next;
      s1_year <= year_next;
      s1_mon  <= mon_next;
      s1_day  <= day_next;
      s1_hour <= hour_next;
      s1_min  <= min_next;
      s1_sec  <= sec_next;
    end
  end

  // Stage 2: partial sums and borrow normalization into digit pairs
  logic signed [dtspv_pkg::YMD_W-1:0] ymd_next;
  logic signed [dtspv_pkg::HMS_W-1:0] hms_next;
  logic signed [PW-1:0] t_min, t_hour, t_day, t_mon;
  logic                 b_sec, b_min, b_hour, b_day, b_mon;
  logic [6:0]           g_sec, g_min, g_hour, g_day, g_mon;
  logic signed [YW-1:0] y_adj;
  logic                 thirty, base_ok_next, feb29_next;

  assign ymd_next = dtspv_pkg::YMD_W'(s1_year) * 28'sd10000
                  + dtspv_pkg::YMD_W'(s1_mon) * 28'sd100
                  + dtspv_pkg::YMD_W'(s1_day);
  assign hms_next = dtspv_pkg::HMS_W'(s1_hour) * 21'sd10000
                  + dtspv_pkg::HMS_W'(s1_min) * 21'sd100
                  + dtspv_pkg::HMS_W'(s1_sec);

  always_comb begin
    b_sec  = s1_sec < 0;
    g_sec  = b_sec ? 7'(s1_sec + 8'sd100) : 7'(s1_sec);
    t_min  = b_sec ? s1_min - 8'sd1 : s1_min;
    b_min  = t_min < 0;
    g_min  = b_min ? 7'(t_min + 8'sd100) : 7'(t_min);
    t_hour = b_min ? s1_hour - 8'sd1 : s1_hour;
    b_hour = t_hour < 0;
    g_hour = b_hour ? 7'(t_hour + 8'sd100) : 7'(t_hour);
    t_day  = b_hour ? s1_day - 8'sd1 : s1_day;
    b_day  = t_day < 0;
    g_day  = b_day ? 7'(t_day + 8'sd100) : 7'(t_day);
    t_mon  = b_day ? s1_mon - 8'sd1 : s1_mon;
    b_mon  = t_mon < 0;
    g_mon  = b_mon ? 7'(t_mon + 8'sd100) : 7'(t_mon);
    y_adj  = b_mon ? s1_year - 15'sd1 : s1_year;

    thirty = (g_mon == 7'd4) || (g_mon == 7'd6) || (g_mon == 7'd9) || (g_mon == 7'd11);
    base_ok_next = (y_adj >= 15'sd1) && (y_adj <= 15'sd9999)
                && (g_mon >= 7'd1) && (g_mon <= 7'd12)
                && (g_day >= 7'd1) && (g_day <= 7'd31)
                && (g_hour <= 7'd23) && (g_min <= 7'd59) && (g_sec <= 7'd59)
                && !(thirty && (g_day > 7'd30))
                && !((g_mon == 7'd2) && (g_day > 7'd29));
    feb29_next = (g_mon == 7'd2) && (g_day == 7'd29);
  end

  dtspv_pkg::form_t                   s2_form;
  logic signed [dtspv_pkg::YMD_W-1:0] s2_ymd;
  logic signed [dtspv_pkg::HMS_W-1:0] s2_hms;
  logic [13:0]                        s2_year;
  logic                               s2_base_ok, s2_feb29;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_form    <= s1_form;
      s2_ymd     <= ymd_next;
      s2_hms     <= hms_next;
      s2_year    <= 14'(y_adj);
      s2_base_ok <= base_ok_next;
      s2_feb29   <= feb29_next;
    end
  end

  // Stage 3: packed value and leap-year check
  logic signed [dtspv_pkg::PACKED_W-1:0] packed_next;
  logic [26:0] q_full;
  logic [7:0]  q100;
  logic [13:0] rem100;
  logic        leap;

  assign packed_next = dtspv_pkg::PACKED_W'(s2_ymd) * dtspv_pkg::SCALE_DAY
                     + dtspv_pkg::PACKED_W'(s2_hms);

  // year / 100 by reciprocal; exact for years below 10000
  assign q_full = 27'(s2_year) * 27'(dtspv_pkg::RECIP_100);
  assign q100   = q_full[dtspv_pkg::RECIP_SHIFT +: 8];
  assign rem100 = s2_year - 14'(q100) * 14'd100;
  assign leap   = (s2_year[1:0] == 2'b00) && ((rem100 != 14'd0) || (q100[1:0] == 2'b00));

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s3_ready) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready) begin
      result_data.packed_value <= packed_next;
      result_data.form_code    <= s2_form;
      result_data.is_valid     <= s2_base_ok && !(s2_feb29 && !leap);
    end
  end

endmodule

// File: rtl/dtspv_checker.sv
// ---------------------------------------------------------------------------
// dtspv_checker
// Port-level checks on the date/time parser's result channel.
// ---------------------------------------------------------------------------
module dtspv_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    char_valid,
  input logic                    char_ready,
  input dtspv_pkg::char_beat_t   char_data,
  input logic                    result_valid,
  input logic                    result_ready,
  input dtspv_pkg::result_beat_t result_data
);

  logic unused_in;
  assign unused_in = char_valid ^ char_ready ^ (^char_data);

  // No result beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> result_valid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> $stable(result_data))
    else $error("result payload changed while stalled");

  // A valid date only comes from a recognized form, with a positive value
  a_valid_form: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.is_valid) |->
      ((result_data.form_code == dtspv_pkg::FORM_DATE)
       || (result_data.form_code == dtspv_pkg::FORM_DATE_SEP)
       || (result_data.form_code == dtspv_pkg::FORM_DATETIME)
       || (result_data.form_code == dtspv_pkg::FORM_DATETIME_SEP))
      && (result_data.packed_value > 0))
    else $error("valid flag on an unrecognized form or non-positive value");

  // Bad length or rejected structure gives a zero, invalid result
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && ((result_data.form_code == dtspv_pkg::FORM_BAD_LEN)
                      || (result_data.form_code == dtspv_pkg::FORM_REJECT))) |->
      ((result_data.packed_value == '0) && !result_data.is_valid))
    else $error("rejected string produced a nonzero or valid result");

endmodule

bind date_time_string_parse_validate dtspv_checker u_dtspv_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_ready   (char_ready),
  .char_data    (char_data),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_data  (result_data)
);

// File: tb/date_time_string_parse_validate_tb.sv
// ---------------------------------------------------------------------------
// date_time_string_parse_validate_tb
// Streams date/time strings into the parser one character per beat and
// checks every result beat against a predictor kept inside the bench.
// Directed strings cover each form, the calendar limits, signed and junk
// fields, separator mismatches and overlong input. Random strings follow,
// mostly well-formed dates with random content, with random gaps on both
// handshakes.
// ---------------------------------------------------------------------------
module date_time_string_parse_validate_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint YEAR_SCALE  = 64'sd10000000000;
  localparam longint MONTH_SCALE = 64'sd100000000;
  localparam longint DAY_SCALE   = 64'sd1000000;
  localparam longint HOUR_SCALE  = 64'sd10000;
  localparam int     RANDOM_CHARS = 280;

  typedef enum int {FIELD_DIGITS, FIELD_NEG, FIELD_JUNK} field_mode_t;

  logic                    clk;
  logic                    rst;
  logic                    char_valid;
  logic                    char_ready;
  dtspv_pkg::char_beat_t   char_data;
  logic                    result_valid;
  logic                    result_ready;
  dtspv_pkg::result_beat_t result_data;

  // Predictor state
  logic [7:0]              held_chars [dtspv_pkg::STORE_DEPTH];
  int                      held_len;
  dtspv_pkg::result_beat_t expected_stamps [$];

  logic [7:0]   line_q [$];
  int           fail_count;
  int           chars_sent;
  int           stall_left;
  bit           quiet;

  date_time_string_parse_validate uut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
  );

  // Clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------------
  function automatic bit is_num_char(input logic [7:0] c);
    return (c >= dtspv_pkg::CHAR_ZERO) && (c <= dtspv_pkg::CHAR_NINE);
  endfunction

  function automatic bit held_all_digits(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (!is_num_char(held_chars[i])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Digit run, or minus-led digit run; anything else is zero
  function automatic longint field_value(input int start, input int n);
    bit     neg;
    longint acc;
    int     i;
    neg = 1'b0;
    acc = 0;
    for (i = 0; i < n; i++) begin
      if (is_num_char(held_chars[start+i])) continue;
      if (i == 0 && held_chars[start+i] == dtspv_pkg::CHAR_MINUS) begin
        neg = 1'b1;
        continue;
      end
      return 0;
    end
    for (i = neg ? 1 : 0; i < n; i++) begin
      acc = acc * 10 + (int'(held_chars[start+i]) - int'(dtspv_pkg::CHAR_ZERO));
    end
    return neg ? -acc : acc;
  endfunction

  function automatic bit calendar_ok(input longint v);
    longint unsigned u, y, mo, d, h, mi, s;
    if (v <= 0) return 1'b0;
    u  = v;
    y  = u / YEAR_SCALE;
    mo = (u / MONTH_SCALE) % 100;
    d  = (u / DAY_SCALE) % 100;
    h  = (u / HOUR_SCALE) % 100;
    mi = (u / 100) % 100;
    s  = u % 100;
    if (y < 1 || y > 9999) return 1'b0;
    if (mo < 1 || mo > 12) return 1'b0;
    if (d < 1 || d > 31) return 1'b0;
    if (h > 23 || mi > 59 || s > 59) return 1'b0;
    if ((mo == 4 || mo == 6 || mo == 9 || mo == 11) && d > 30) return 1'b0;
    if (mo == 2) begin
      if (d > 29) return 1'b0;
      // leap day: divisible by 4, centuries only when divisible by 400
      if (d == 29 && !((y % 4 == 0) && (y % 100 != 0 || y % 400 == 0))) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Take one accepted character; on the final one queue the expected beat
  task automatic absorb_char(input logic [7:0] c, input logic last);
    int                      n;
    longint                  v;
    dtspv_pkg::form_t        f;
    dtspv_pkg::result_beat_t r;
    if (held_len < dtspv_pkg::STORE_DEPTH) held_chars[held_len] = c;
    if (held_len < dtspv_pkg::COUNT_MAX) held_len++;
    if (!last) return;
    n        = held_len;
    held_len = 0;
    v        = 0;
    f        = dtspv_pkg::FORM_BAD_LEN;
    if (n == dtspv_pkg::LEN_DATE) begin
      if (held_all_digits(8)) begin
        f = dtspv_pkg::FORM_DATE;
        v = field_value(0, 4) * YEAR_SCALE + field_value(4, 2) * MONTH_SCALE
          + field_value(6, 2) * DAY_SCALE;
      end else begin
        f = dtspv_pkg::FORM_REJECT;
      end
    end else if (n == dtspv_pkg::LEN_DATE_SEP) begin
      if (held_chars[4] == held_chars[7]) begin
        f = dtspv_pkg::FORM_DATE_SEP;
        v = field_value(0, 4) * YEAR_SCALE + field_value(5, 2) * MONTH_SCALE
          + field_value(8, 2) * DAY_SCALE;
      end else begin
        f = dtspv_pkg::FORM_REJECT;
      end
    end else if (n == dtspv_pkg::LEN_DATETIME) begin
      if (held_all_digits(14)) begin
        f = dtspv_pkg::FORM_DATETIME;
        v = field_value(0, 4) * YEAR_SCALE + field_value(4, 2) * MONTH_SCALE
          + field_value(6, 2) * DAY_SCALE + field_value(8, 2) * HOUR_SCALE
          + field_value(10, 2) * 100 + field_value(12, 2);
      end else begin
        f = dtspv_pkg::FORM_REJECT;
      end
    end else if (n == dtspv_pkg::LEN_DATETIME_SEP) begin
      if (held_chars[4] == held_chars[7] && held_chars[13] == held_chars[16]) begin
        f = dtspv_pkg::FORM_DATETIME_SEP;
        v = field_value(0, 4) * YEAR_SCALE + field_value(5, 2) * MONTH_SCALE
          + field_value(8, 2) * DAY_SCALE + field_value(11, 2) * HOUR_SCALE
          + field_value(14, 2) * 100 + field_value(17, 2);
      end else begin
        f = dtspv_pkg::FORM_REJECT;
      end
    end
    r.packed_value = v[dtspv_pkg::PACKED_W-1:0];
    r.form_code    = f;
    r.is_valid     = calendar_ok(v);
    expected_stamps.push_back(r);
  endtask

  // ------------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : check_results
    dtspv_pkg::result_beat_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_stamps.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_stamps.pop_front();
        if (result_data.packed_value !== want.packed_value)
          report_mismatch($sformatf("packed_value %0d, expected %0d",
                                    result_data.packed_value, want.packed_value));
        if (result_data.form_code !== want.form_code)
          report_mismatch($sformatf("form_code %0d, expected %0d",
                                    result_data.form_code, want.form_code));
        if (result_data.is_valid !== want.is_valid)
          report_mismatch($sformatf("is_valid %0b, expected %0b (value %0d)",
                                    result_data.is_valid, want.is_valid,
                                    want.packed_value));
      end
    end
  end

  // ------------------------------------------------------------------------
  // Handshake drivers
  // ------------------------------------------------------------------------
  // Mostly no gap or a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      result_ready <= 1'b0;
      stall_left--;
    end else begin
      result_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // Send one character beat and feed the predictor once it is accepted
  task automatic send_beat(input logic [7:0] c, input logic last);
    int                    gap;
    dtspv_pkg::char_beat_t beat;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat.char_code = c;
    beat.last_char = last;
    char_valid <= 1'b1;
    char_data  <= beat;
    @(posedge clk);
    while (!char_ready) @(posedge clk);
    absorb_char(c, last);
    chars_sent++;
  endtask

  task automatic send_line();
    int i;
    for (i = 0; i < line_q.size(); i++) send_beat(line_q[i], i == line_q.size() - 1);
    line_q.delete();
  endtask

  // Hold the sender until every expected beat is back
  task automatic wait_drained();
    char_valid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // ------------------------------------------------------------------------
  // String builders
  // ------------------------------------------------------------------------
  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic push_num(input int val, input int width);
    int i, div;
    div = 1;
    for (i = 1; i < width; i++) div *= 10;
    for (i = 0; i < width; i++) begin
      line_q.push_back(8'(int'(dtspv_pkg::CHAR_ZERO) + (val / div) % 10));
      div /= 10;
    end
  endtask

  task automatic push_field(input int val, input int width, input field_mode_t mode);
    int i, r;
    case (mode)
      FIELD_DIGITS: push_num(val, width);
      FIELD_NEG: begin
        line_q.push_back(dtspv_pkg::CHAR_MINUS);
        push_num(val, width - 1);
      end
      default: begin
        for (i = 0; i < width; i++) begin
          r = $urandom_range(0, 2);
          if (r == 0) line_q.push_back(dtspv_pkg::CHAR_MINUS);
          else if (r == 1)
            line_q.push_back(8'($urandom_range(dtspv_pkg::CHAR_ZERO, dtspv_pkg::CHAR_NINE)));
          else line_q.push_back(8'($urandom_range(0, 255)));
        end
      end
    endcase
  endtask

  function automatic logic [7:0] pick_sep();
    case ($urandom_range(0, 6))
      0: return dtspv_pkg::CHAR_MINUS;
      1: return "/";
      2: return ":";
      3: return " ";
      4: return "T";
      5: return ".";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic field_mode_t pick_mode(input bit mixed);
    int r;
    if (!mixed) return FIELD_DIGITS;
    r = $urandom_range(0, 9);
    if (r < 5) return FIELD_DIGITS;
    if (r < 8) return FIELD_NEG;
    return FIELD_JUNK;
  endfunction

  // One random line: mostly well-formed dates, the rest broken or noise
  task automatic build_random_line();
    int               kind, y, mo, d, h, mi, s, i, n;
    dtspv_pkg::form_t f;
    bit               mixed;
    logic [7:0]       sep_a, sep_b, mid;
    kind = $urandom_range(0, 99);
    if (kind < 85) begin
      f = dtspv_pkg::form_t'($urandom_range(dtspv_pkg::FORM_DATE,
                                            dtspv_pkg::FORM_DATETIME_SEP));
      case ($urandom_range(0, 3))
        0: y = $urandom_range(0, 9999);
        1: y = $urandom_range(1900, 2100);
        default: begin
          case ($urandom_range(0, 7))
            0: y = 0;
            1: y = 1;
            2: y = 1900;
            3: y = 2000;
            4: y = 2004;
            5: y = 2100;
            6: y = 2400;
            default: y = 9999;
          endcase
        end
      endcase
      mo = $urandom_range(0, 13);
      d  = $urandom_range(0, 32);
      h  = $urandom_range(0, 24);
      mi = $urandom_range(0, 60);
      s  = $urandom_range(0, 60);
      // steer toward the leap-day and 30-day month edges
      if ($urandom_range(0, 4) == 0) begin
        mo = 2;
        d  = $urandom_range(28, 30);
      end else if ($urandom_range(0, 4) == 0) begin
        mo = $urandom_range(0, 1) ? 4 : 11;
        d  = $urandom_range(30, 31);
      end
      mixed = (kind >= 60 && kind < 75);
      sep_a = pick_sep();
      sep_b = pick_sep();
      mid   = pick_sep();
      case (f)
        dtspv_pkg::FORM_DATE: begin
          push_num(y, 4); push_num(mo, 2); push_num(d, 2);
        end
        dtspv_pkg::FORM_DATETIME: begin
          push_num(y, 4); push_num(mo, 2); push_num(d, 2);
          push_num(h, 2); push_num(mi, 2); push_num(s, 2);
        end
        dtspv_pkg::FORM_DATE_SEP: begin
          push_field(y, 4, pick_mode(mixed)); line_q.push_back(sep_a);
          push_field(mo, 2, pick_mode(mixed)); line_q.push_back(sep_a);
          push_field(d, 2, pick_mode(mixed));
        end
        default: begin
          push_field(y, 4, pick_mode(mixed)); line_q.push_back(sep_a);
          push_field(mo, 2, pick_mode(mixed)); line_q.push_back(sep_a);
          push_field(d, 2, pick_mode(mixed)); line_q.push_back(mid);
          push_field(h, 2, pick_mode(mixed)); line_q.push_back(sep_b);
          push_field(mi, 2, pick_mode(mixed)); line_q.push_back(sep_b);
          push_field(s, 2, pick_mode(mixed));
        end
      endcase
      // corrupt one character
      if (kind >= 75) line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
    end else begin
      if (kind < 95) begin
        n = $urandom_range(1, 24);
      end else begin
        case ($urandom_range(0, 3))
          0: n = dtspv_pkg::LEN_DATE;
          1: n = dtspv_pkg::LEN_DATE_SEP;
          2: n = dtspv_pkg::LEN_DATETIME;
          default: n = dtspv_pkg::LEN_DATETIME_SEP;
        endcase
      end
      for (i = 0; i < n; i++) begin
        if ($urandom_range(0, 1))
          line_q.push_back(8'($urandom_range(dtspv_pkg::CHAR_ZERO, dtspv_pkg::CHAR_NINE)));
        else line_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  task automatic test_compact_forms();
    push_text("20240229"); send_line();        // leap day
    push_text("19000229"); send_line();        // century, not leap
    push_text("20000229"); send_line();        // divisible by 400
    push_text("00000101"); send_line();        // year zero
    push_text("2024010A"); send_line();        // non-digit
    push_text("00010101000000"); send_line();  // smallest valid
    push_text("99991231235959"); send_line();  // largest value
    push_text("20241231240000"); send_line();  // hour out of range
  endtask

  task automatic test_separated_forms();
    push_text("2023-04-31"); send_line();      // 30-day month
    push_text("2024-13-01"); send_line();
    push_text("2024-06-00"); send_line();
    push_text("2024101101"); send_line();      // digit separators that match
    push_text("2024-01/01"); send_line();      // separator mismatch
    push_text("9999-12-31T23:59:59"); send_line();
    push_text("2024-01-01 23:60:59"); send_line();
    push_text("2024-01-01"); line_q.push_back(8'hA5); push_text("12:34:60"); send_line();
    push_text("2024-01-01T12:34-56"); send_line();
  endtask

  task automatic test_field_signs();
    push_text("-999-01-01"); send_line();      // negative year
    push_text("2024--5-01"); send_line();      // negative month
    push_text("2024-ab-01"); send_line();      // junk field is zero
    push_text("-ab1/12/31"); send_line();
    push_text("2024/01/01 -1:-0:-9"); send_line();
  endtask

  task automatic test_length_edges();
    push_text("-"); send_line();
    push_text("202401011"); send_line();
    push_text("2024-01-01T00:00:00"); send_line();
    push_text("2024-01-01T00:00:00ZZZZZ"); send_line();  // count saturates
    line_q.push_back(8'hFF); line_q.push_back(8'h00); send_line();
  endtask

  task automatic test_random_strings();
    int lines;
    lines = 0;
    while (chars_sent < RANDOM_CHARS) begin
      quiet = (lines % 25) >= 20;   // bursts with no idling
      build_random_line();
      send_line();
      lines++;
      if (lines == 30) wait_drained();
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    char_valid   <= 1'b0;
    char_data    <= '0;
    result_ready <= 1'b0;
    held_len     = 0;
    fail_count   = 0;
    chars_sent   = 0;
    stall_left   = 0;
    quiet        = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_compact_forms();
    test_separated_forms();
    wait_drained();
    test_field_signs();
    test_length_edges();
    wait_drained();
    chars_sent = 0;
    test_random_strings();

    quiet = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dtspv_pkg.sv
rtl/date_time_string_parse_validate.sv
rtl/dtspv_checker.sv
tb/date_time_string_parse_validate_tb.sv
